[rtl/core/twsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsm_pkg
// Shared types and constants for the two-way sorted merge unit.
// ----------------------------------------------------------------------------
package twsm_pkg;

  // Port width of a key on both channels
  localparam int unsigned KEY_W = 16;

  typedef enum logic [0:0] {
    ST_LOAD  = 1'b0,
    ST_MERGE = 1'b1
  } twsm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_a;      // write key into list A at its fill position
    logic load_b;      // write key into list B at its fill position
    logic merge_step;  // produce one merged result into the output register
  } twsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full_a;      // list A holds LIST_LEN keys
    logic full_b;
    logic almost_a;    // list A is one key short of full
    logic almost_b;
    logic last_step;   // next merge step produces the final result
    logic out_free;    // output register can take a result this cycle
  } twsm_status_t;

endpackage

[rtl/core/twsm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsm_ctrl
// Load / merge sequencer: steers input items and paces the merge steps.
// ----------------------------------------------------------------------------
module twsm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_list_sel,
  input  twsm_pkg::twsm_status_t status,
  output twsm_pkg::twsm_cmd_t    cmd
);
  import twsm_pkg::*;

  twsm_state_t state_r, state_nxt;
  logic        acc;
  logic        completes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign acc = in_valid && (state_r == ST_LOAD);

  // The item that fills the second list starts the merge
  assign completes = acc &&
      ((!in_list_sel && status.almost_a && status.full_b) ||
       ( in_list_sel && status.almost_b && status.full_a));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (completes) state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (status.out_free && status.last_step) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.load_a     = 1'b0;
    cmd.load_b     = 1'b0;
    cmd.merge_step = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready   = 1'b1;
        // drop items aimed at a full list
        cmd.load_a = acc && !in_list_sel && !status.full_a;
        cmd.load_b = acc &&  in_list_sel && !status.full_b;
      end
      ST_MERGE: begin
        cmd.merge_step = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/twsm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsm_datapath
// Key stores, fill counts, merge pointers and the result output register.
// ----------------------------------------------------------------------------
module twsm_datapath #(
  parameter int unsigned LIST_LEN = 8,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [twsm_pkg::KEY_W-1:0] in_key,
  input  twsm_pkg::twsm_cmd_t         cmd,
  output twsm_pkg::twsm_status_t      status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [twsm_pkg::KEY_W-1:0] out_merged_key,
  output logic                       out_from_list,
  output logic                       out_last
);
  import twsm_pkg::*;

  localparam int unsigned SW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned CW    = $clog2(LIST_LEN + 1);
  localparam int unsigned IW    = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
  localparam int unsigned TOTAL = 2 * LIST_LEN;
  localparam int unsigned KW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam logic [CW-1:0] LEN_C   = CW'(LIST_LEN);
  localparam logic [CW-1:0] ALMOST  = CW'(LIST_LEN - 1);
  localparam logic [KW-1:0] K_LAST  = KW'(TOTAL - 1);

  logic [SW-1:0] store_a [LIST_LEN];
  logic [SW-1:0] store_b [LIST_LEN];

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic [KW-1:0] k_r, k_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0] out_key_r;
  logic          out_from_r, out_last_r;

  logic [SW-1:0] head_a_r, head_b_r;
  logic          take_a;
  logic          final_step;

  // Key writes; read the next list heads into registers, passing a key that
  // is written to the entry being read straight through
  always_ff @(posedge clk) begin
    if (cmd.load_a) store_a[cnt_a_r[IW-1:0]] <= in_key[SW-1:0];
    if (cmd.load_b) store_b[cnt_b_r[IW-1:0]] <= in_key[SW-1:0];
    if (cmd.load_a && (cnt_a_r[IW-1:0] == ia_nxt[IW-1:0])) begin
      head_a_r <= in_key[SW-1:0];
    end else begin
      head_a_r <= store_a[ia_nxt[IW-1:0]];
    end
    if (cmd.load_b && (cnt_b_r[IW-1:0] == ib_nxt[IW-1:0])) begin
      head_b_r <= in_key[SW-1:0];
    end else begin
      head_b_r <= store_b[ib_nxt[IW-1:0]];
    end
  end

  // Take A only when strictly smaller; ties go to B
  assign take_a     = (ia_r < LEN_C) && ((ib_r >= LEN_C) || (head_a_r < head_b_r));
  assign final_step = cmd.merge_step && (k_r == K_LAST);

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ia_nxt    = ia_r;
    ib_nxt    = ib_r;
    k_nxt     = k_r;
    if (cmd.load_a) cnt_a_nxt = cnt_a_r + CW'(1);
    if (cmd.load_b) cnt_b_nxt = cnt_b_r + CW'(1);
    if (cmd.merge_step) begin
      k_nxt = k_r + KW'(1);
      if (take_a) ia_nxt = ia_r + CW'(1);
      else        ib_nxt = ib_r + CW'(1);
    end
    if (final_step) begin
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      ia_nxt    = '0;
      ib_nxt    = '0;
      k_nxt     = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.merge_step)  out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge_step) begin
      out_key_r  <= take_a ? KEY_W'(head_a_r) : KEY_W'(head_b_r);
      out_from_r <= !take_a;
      out_last_r <= (k_r == K_LAST);
    end
  end

  assign status.full_a    = (cnt_a_r == LEN_C);
  assign status.full_b    = (cnt_b_r == LEN_C);
  assign status.almost_a  = (cnt_a_r == ALMOST);
  assign status.almost_b  = (cnt_b_r == ALMOST);
  assign status.last_step = (k_r == K_LAST);
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_merged_key = out_key_r;
  assign out_from_list  = out_from_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= LEN_C) && (cnt_b_r <= LEN_C))
    else $error("fill count beyond list length");

  a_merge_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> (status.full_a && status.full_b))
    else $error("merge step with a list not full");

  a_ptr_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW + 1)'(ia_r) + (CW + 1)'(ib_r)) == (CW + 1)'(k_r))
    else $error("merge pointers out of step with result count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    final_step |=> (cnt_a_r == '0) && (cnt_b_r == '0) && out_last)
    else $error("counts not cleared after final result");

  a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> !(cmd.load_a || cmd.load_b))
    else $error("key write during merge");
`endif

endmodule

[rtl/core/two_way_sorted_merge_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_sorted_merge_unit
// Loads two ascending key lists and streams out their ascending merge.
// ----------------------------------------------------------------------------
// Send keys one item per cycle; in_list_sel picks list A (0) or B (1), and
// each list takes LIST_LEN keys in ascending order. An item sent to a list
// that is already full is accepted and dropped. The item that fills the last
// open list starts the merge: the block then emits 2*LIST_LEN items, one per
// cycle while out_ready is high, in ascending order, with out_from_list
// naming the source list. On equal keys the B key comes first. out_last
// marks the final item of the run, after which both lists are empty again
// and in_ready returns. A merge holds the input and makes one compare of the
// two list heads per cycle while the output register can take a result. A
// result register on the output lets the next load start while the final
// merged item still waits. Keys are stored in the low KEY_BITS bits, at most
// KEY_W.
// ----------------------------------------------------------------------------
module two_way_sorted_merge_unit #(
  parameter int unsigned LIST_LEN = 8,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_list_sel,
  input  logic [twsm_pkg::KEY_W-1:0] in_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [twsm_pkg::KEY_W-1:0] out_merged_key,
  output logic                       out_from_list,
  output logic                       out_last
);
  import twsm_pkg::*;

  twsm_cmd_t    cmd;
  twsm_status_t status;

  // Sequencer: decide loads, hold input during the merge
  twsm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_list_sel (in_list_sel),
    .status      (status),
    .cmd         (cmd)
  );

  // Stores, pointers and output register
  twsm_datapath #(
    .LIST_LEN (LIST_LEN),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_key         (in_key),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_merged_key (out_merged_key),
    .out_from_list  (out_from_list),
    .out_last       (out_last)
  );

endmodule
